### rtl/ph6_pkg.sv
// Shared types, constants and helpers of the six-stage allpass phaser.
`default_nettype none

package ph6_pkg;

   localparam int STAGES_DEF       = 6;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int SINE_TABLE_DEPTH = 256;          // power of two
   localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
   localparam int TAB_ADDR_W       = IDX_W + 1;

   localparam int STATE_W   = 24;                  // allpass and feedback states
   localparam int COEF_W    = 17;                  // Q0.16 values up to 1.0
   localparam int MUL_A_W   = 25;
   localparam int MUL_B_W   = 18;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int SUM_W     = 48;
   localparam int DIV_STEPS = COEF_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [COEF_W-1:0] ONE_Q16 = COEF_W'(65536);
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // Taylor series divisors (2k)*(2k+1) for k = 1..8
   localparam longint TAYLOR_DEN [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

   localparam logic signed [SUM_W-1:0] S24_MAX = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0] S24_MIN = ~S24_MAX;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SWEEP_MUL,
      S_SWEEP_ADD,
      S_DIV,
      S_FB_MUL,
      S_FB_ADD,
      S_AP_MUL1,
      S_AP_OUT,
      S_AP_MUL2,
      S_AP_MEM,
      S_MIX_MUL,
      S_MIX_OUT
   } ph6_state_type;

   typedef enum logic [2:0] {
      REG_SWEEP_MIN   = 3'd0,
      REG_SWEEP_MAX   = 3'd1,
      REG_PHASE_STEP  = 3'd2,
      REG_FB_GAIN     = 3'd3,
      REG_MIX_DEPTH   = 3'd4,
      REG_START_PHASE = 3'd5
   } ph6_reg_type;

   typedef logic [COEF_W-1:0] sine_tab_type [0:SINE_TABLE_DEPTH];

   // Quarter-wave sine, Q0.16, from a Q30 Taylor series (elaboration only).
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type t;
      longint x;
      longint x2;
      longint term;
      longint sum;
      int i;
      int k;
      for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
         x2   = (x * x) >>> 30;
         term = x;
         sum  = x;
         for (k = 1; k <= 8; k++) begin
            term = ((term * x2) >>> 30) / TAYLOR_DEN[k];
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         if (sum < 0) sum = 0;
         sum = (sum * 65536 + (longint'(1) <<< 29)) >>> 30;
         if (sum > 65536) sum = 65536;
         t[i] = COEF_W'(sum);
      end
      return t;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   function automatic logic signed [SUM_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] p);
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(p);
      return (s + SUM_W'(32768)) >>> 16;
   endfunction

   function automatic logic signed [SUM_W-1:0] rnd_q15(input logic signed [PROD_W-1:0] p);
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(p);
      return (s + SUM_W'(16384)) >>> 15;
   endfunction

   function automatic logic signed [STATE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] c;
      if (v > S24_MAX) c = S24_MAX;
      else if (v < S24_MIN) c = S24_MIN;
      else c = v;
      return c[STATE_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/six_stage_allpass_phaser_core.sv
// Six-stage allpass phaser: LFO, coefficient divider and shared-multiplier sequencer.
//
// Usage:
//  req_* carries one signed input sample per request (tdata bits [SAMPLE_WIDTH-1:0]).
//  rsp_* returns exactly one phased, saturated sample for every request, in order.
//  csr_* writes one register per handshake (index 0..5: sweep_min, sweep_max,
//  phase_step, feedback_gain, mix_depth, start_phase); a start_phase write also
//  loads the LFO phase. Indexes 6 and 7 are ignored. csr_ready is always high;
//  write only while no request is in flight.
// Timing:
//  A request occupies the block until its result is registered, and req_tready
//  is high only in the idle state. The occupancy is set by the single
//  shared 25x18 multiplier (two passes per allpass stage plus the sweep, the
//  feedback and the mix products) and the restoring divider for a1.
// Stalls: the result sits in an output register, so the next request is taken
//  while rsp waits; a second result waits in the last state until rsp frees.
// Reset: synchronous, active high. Registers return to their defaults, the LFO
//  phase, allpass states and feedback state clear. The sine table is constant.
`default_nettype none

module six_stage_allpass_phaser_core
   import ph6_pkg::*;
#(
   parameter int STAGES       = STAGES_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   // input samples
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]  req_tdata,   // sample_in
   // phased samples
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  rsp_tdata,   // sample_out
   // register writes
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [2:0]                         csr_index,
   input  wire  [31:0]                        csr_data
);

   localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int STG_W   = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [SUM_W-1:0] OUT_MIN = ~OUT_MAX;

   // control state
   ph6_state_type state_ff, state_in;
   logic [16:0]                 sweep_min_ff, sweep_max_ff;
   logic [31:0]                 phase_step_ff, lfo_phase_ff;
   logic [14:0]                 fb_gain_ff;
   logic [15:0]                 mix_depth_ff;
   logic signed [STATE_W-1:0]   ap_mem_ff [STAGES];
   logic signed [STATE_W-1:0]   fb_ff;
   logic [DIV_CNT_W-1:0]        div_cnt_ff;
   logic [STG_W-1:0]            stg_cnt_ff;
   logic                        rsp_valid_ff;

   // payload
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic [COEF_W-1:0]              u_ff;
   logic signed [PROD_W-1:0]       prod_ff;
   logic [COEF_W-1:0]              rem_ff, quo_ff;
   logic [COEF_W:0]                den_ff;
   logic signed [STATE_W-1:0]      y_ff, sin_ff;
   logic [SAMPLE_WIDTH-1:0]        rsp_data_ff;

   // combinational
   logic                        mul_en;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic [COEF_W-1:0]           lo, hi;
   logic signed [COEF_W:0]      sweep_diff;
   logic [IDX_W-1:0]            tab_idx;
   logic [TAB_ADDR_W-1:0]       tab_addr;
   logic [COEF_W-1:0]           sine_mag;
   logic [COEF_W:0]             u_sum;
   logic signed [SUM_W-1:0]     d_q, d_sum;
   logic [COEF_W-1:0]           d_val;
   logic [COEF_W:0]             den_val;
   logic [2*COEF_W-1:0]         num_val;
   logic [COEF_W:0]             div_trial;
   logic                        div_ge;
   logic                        out_free, last_stage;
   logic signed [STATE_W-1:0]   ap_out, ap_new, fb_in;
   logic signed [SUM_W-1:0]     mix_sum, mix_sat;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_stage = (stg_cnt_ff == STG_W'(STAGES - 1));

   // sweep limits clamp at 1.0
   assign lo = (sweep_min_ff > ONE_Q16) ? ONE_Q16 : sweep_min_ff;
   assign hi = (sweep_max_ff > ONE_Q16) ? ONE_Q16 : sweep_max_ff;
   assign sweep_diff = $signed({1'b0, hi}) - $signed({1'b0, lo});

   // quarter-wave lookup; odd quadrants mirror, upper half negates
   assign tab_idx  = lfo_phase_ff[29 -: IDX_W];
   assign tab_addr = lfo_phase_ff[30] ? (TAB_ADDR_W'(SINE_TABLE_DEPTH) - {1'b0, tab_idx})
                                      : {1'b0, tab_idx};
   assign sine_mag = SINE_TAB[tab_addr];
   assign u_sum    = lfo_phase_ff[31] ? ({1'b0, ONE_Q16} - {1'b0, sine_mag})
                                      : ({1'b0, ONE_Q16} + {1'b0, sine_mag});

   // d = lo + (hi-lo)*u/65536, truncated toward zero
   assign d_q     = prod_ff[PROD_W-1] ? ((SUM_W'(prod_ff) + SUM_W'(65535)) >>> 16)
                                      : (SUM_W'(prod_ff) >>> 16);
   assign d_sum   = $signed({{(SUM_W-COEF_W){1'b0}}, lo}) + d_q;
   assign d_val   = d_sum[COEF_W-1:0];
   assign den_val = {1'b0, ONE_Q16} + {1'b0, d_val};
   assign num_val = (2*COEF_W)'({(ONE_Q16 - d_val), 16'd0}) + (2*COEF_W)'(den_val >> 1);

   // restoring divider step, quotient shifts in where the numerator shifts out
   assign div_trial = {rem_ff, quo_ff[COEF_W-1]};
   assign div_ge    = (div_trial >= den_ff);

   assign fb_in   = sat24(SUM_W'(x_ff) + rnd_q15(prod_ff));
   assign ap_out  = sat24(SUM_W'(ap_mem_ff[stg_cnt_ff]) - rnd_q16(prod_ff));
   assign ap_new  = sat24(rnd_q16(prod_ff) + SUM_W'(sin_ff));
   assign mix_sum = SUM_W'(x_ff) + rnd_q15(prod_ff);
   assign mix_sat = (mix_sum > OUT_MAX) ? OUT_MAX : ((mix_sum < OUT_MIN) ? OUT_MIN : mix_sum);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_tvalid) state_in = S_SWEEP_MUL;
         S_SWEEP_MUL: state_in = S_SWEEP_ADD;
         S_SWEEP_ADD: state_in = S_DIV;
         S_DIV:       if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = S_FB_MUL;
         S_FB_MUL:    state_in = S_FB_ADD;
         S_FB_ADD:    state_in = S_AP_MUL1;
         S_AP_MUL1:   state_in = S_AP_OUT;
         S_AP_OUT:    state_in = S_AP_MUL2;
         S_AP_MUL2:   state_in = S_AP_MEM;
         S_AP_MEM:    state_in = last_stage ? S_MIX_MUL : S_AP_MUL1;
         S_MIX_MUL:   state_in = S_MIX_OUT;
         S_MIX_OUT:   if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // outputs: handshake and multiplier operands
   always_comb begin
      req_tready = 1'b0;
      mul_en     = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_SWEEP_MUL: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(sweep_diff);
            mul_b  = $signed({1'b0, u_ff});
         end
         S_FB_MUL: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(fb_ff);
            mul_b  = $signed(MUL_B_W'(fb_gain_ff));
         end
         S_AP_MUL1, S_AP_MUL2: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(y_ff);
            mul_b  = $signed({1'b0, quo_ff});
         end
         S_MIX_MUL: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(y_ff);
            mul_b  = $signed(MUL_B_W'(mix_depth_ff));
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sweep_min_ff  <= 17'd6687;
         sweep_max_ff  <= 17'd65536;
         phase_step_ff <= 32'd48695;
         fb_gain_ff    <= 15'd12517;
         mix_depth_ff  <= 16'd32768;
         lfo_phase_ff  <= '0;
         fb_ff         <= '0;
         div_cnt_ff    <= '0;
         stg_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < STAGES; i++) ap_mem_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_SWEEP_MIN:   sweep_min_ff  <= csr_data[16:0];
               REG_SWEEP_MAX:   sweep_max_ff  <= csr_data[16:0];
               REG_PHASE_STEP:  phase_step_ff <= csr_data;
               REG_FB_GAIN:     fb_gain_ff    <= csr_data[14:0];
               REG_MIX_DEPTH:   mix_depth_ff  <= csr_data[15:0];
               REG_START_PHASE: lfo_phase_ff  <= csr_data;
               default: ;
            endcase
         end else if (state_ff == S_IDLE && req_tvalid) begin
            lfo_phase_ff <= lfo_phase_ff + phase_step_ff;
         end
         // counter returns to zero on the last divide step
         if (state_ff == S_DIV && div_cnt_ff != DIV_CNT_W'(DIV_STEPS - 1))
            div_cnt_ff <= div_cnt_ff + 1'b1;
         else div_cnt_ff <= '0;
         if (state_ff == S_FB_ADD) stg_cnt_ff <= '0;
         else if (state_ff == S_AP_MEM && !last_stage) stg_cnt_ff <= stg_cnt_ff + 1'b1;
         if (state_ff == S_AP_MEM) ap_mem_ff[stg_cnt_ff] <= ap_new;
         if (state_ff == S_MIX_MUL) fb_ff <= y_ff;
         if (state_ff == S_MIX_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= mul_a * mul_b;
      case (state_ff)
         S_IDLE: begin
            x_ff <= $signed(req_tdata[SAMPLE_WIDTH-1:0]);
            u_ff <= u_sum[COEF_W:1];
         end
         S_SWEEP_ADD: begin
            rem_ff <= num_val[2*COEF_W-1:COEF_W];
            quo_ff <= num_val[COEF_W-1:0];
            den_ff <= den_val;
         end
         S_DIV: begin
            rem_ff <= div_ge ? COEF_W'(div_trial - den_ff) : div_trial[COEF_W-1:0];
            quo_ff <= {quo_ff[COEF_W-2:0], div_ge};
         end
         S_FB_ADD: y_ff <= fb_in;
         S_AP_OUT: begin
            sin_ff <= y_ff;
            y_ff   <= ap_out;
         end
         S_MIX_OUT: if (out_free) rsp_data_ff <= mix_sat[SAMPLE_WIDTH-1:0];
         default: ;
      endcase
   end

   // checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_SWEEP_MUL))
      else $error("accepted request did not start the sequence");

   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FB_MUL) |-> (quo_ff <= ONE_Q16))
      else $error("allpass coefficient above 1.0");

   a_div_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DIV) |-> (div_cnt_ff == '0))
      else $error("divider count active outside division");

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      (int'(stg_cnt_ff) < STAGES))
      else $error("stage index out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_MIX_OUT))
      else $error("result raised outside the output state");

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the six-stage allpass phaser core.
module tb;
   import ph6_pkg::*;

   localparam int CLK_HALF    = 6;
   localparam int RESET_TICKS = 7;
   localparam int RUN_SAMPLES = 90;      // requests per randomized phase
   localparam int RAND_PHASES = 6;
   localparam int DRAIN_GUARD = 20000;   // cycles allowed for the last results
   localparam int TAIL_TICKS  = 60;      // a bit more than one request's latency

   // indexes past the register file; writes there must change nothing
   localparam logic [2:0] REG_SPARE_6 = 3'd6;
   localparam logic [2:0] REG_SPARE_7 = 3'd7;

   localparam logic signed [15:0] EDGE_SAMPLES [12] = '{
      16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'sd32767,
      16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sh5555, 16'shAAAA
   };

   // ------------------------------------------------------------------------
   // Predictor and result store. Tracks LFO phase, allpass and feedback state
   // and the register file; every accepted request pushes its phased sample.
   // ------------------------------------------------------------------------
   class phaser_tracker;
      longint           quarter_sine [0:SINE_TABLE_DEPTH];
      logic [16:0]      sweep_lo;
      logic [16:0]      sweep_hi;
      logic [31:0]      lfo_step;
      logic [14:0]      fb_gain;
      logic [15:0]      mix_gain;
      logic [31:0]      lfo_phase;
      longint           ap_state [STAGES_DEF];
      longint           fb_state;
      logic signed [15:0] pending_out [$];
      int               mismatches;

      function new();
         longint ang;
         longint ang2;
         longint term;
         longint acc;
         int     i;
         int     k;
         // quarter-wave table, Q30 Taylor series rounded to Q0.16
         for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            ang  = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
            ang2 = (ang * ang) >>> 30;
            term = ang;
            acc  = ang;
            for (k = 1; k <= 8; k++) begin
               term = ((term * ang2) >>> 30) / longint'((2 * k) * (2 * k + 1));
               acc  = (k % 2 == 1) ? acc - term : acc + term;
            end
            if (acc < 0) acc = 0;
            acc = (acc * 65536 + (longint'(1) <<< 29)) >>> 30;
            quarter_sine[i] = (acc > 65536) ? 65536 : acc;
         end
         sweep_lo  = 17'd6687;
         sweep_hi  = 17'd65536;
         lfo_step  = 32'd48695;
         fb_gain   = 15'd12517;
         mix_gain  = 16'd32768;
         lfo_phase = '0;
         foreach (ap_state[i]) ap_state[i] = 0;
         fb_state   = 0;
         mismatches = 0;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function longint clip24(longint v);
         return clip(v, -64'sd8388608, 64'sd8388607);
      endfunction

      function longint round_q16(longint p);
         return (p + 32768) >>> 16;
      endfunction

      function longint round_q15(longint p);
         return (p + 16384) >>> 15;
      endfunction

      function void apply_write(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_SWEEP_MIN:   sweep_lo = val[16:0];
            REG_SWEEP_MAX:   sweep_hi = val[16:0];
            REG_PHASE_STEP:  lfo_step = val;
            REG_FB_GAIN:     fb_gain  = val[14:0];
            REG_MIX_DEPTH:   mix_gain = val[15:0];
            REG_START_PHASE: lfo_phase = val;
            default: ;
         endcase
      endfunction

      function void take_sample(logic signed [15:0] smp);
         longint x;
         longint lo;
         longint hi;
         longint sine;
         longint u;
         longint d;
         longint a1;
         longint g_fb;
         longint g_mix;
         longint v;
         longint o;
         longint res;
         int     idx;
         int     i;
         x     = smp;
         g_fb  = fb_gain;
         g_mix = mix_gain;
         lo    = (sweep_lo > 17'd65536) ? 65536 : longint'(sweep_lo);
         hi    = (sweep_hi > 17'd65536) ? 65536 : longint'(sweep_hi);

         // quadrant from the top two phase bits, table index from the next eight
         idx  = lfo_phase[29:22];
         sine = lfo_phase[30] ? quarter_sine[SINE_TABLE_DEPTH - idx] : quarter_sine[idx];
         if (lfo_phase[31]) sine = -sine;
         u = (sine + 65536) / 2;
         d = lo + ((hi - lo) * u) / 65536;     // truncates toward zero on a down sweep
         lfo_phase = lfo_phase + lfo_step;
         a1 = ((65536 - d) * 65536 + (65536 + d) / 2) / (65536 + d);

         v = clip24(x + round_q15(fb_state * g_fb));
         for (i = 0; i < STAGES_DEF; i++) begin
            o           = clip24(ap_state[i] - round_q16(v * a1));
            ap_state[i] = clip24(round_q16(o * a1) + v);
            v           = o;
         end
         fb_state = v;
         res = clip(x + round_q15(v * g_mix), -32768, 32767);
         pending_out.push_back(res[15:0]);
      endfunction

      function void check_output(logic signed [15:0] got);
         logic signed [15:0] want;
         if (pending_out.size() == 0) begin
            $error("sample_out: expected nothing, got %0d", got);
            mismatches++;
         end else begin
            want = pending_out.pop_front();
            if (got !== want) begin
               $error("sample_out: expected %0d, got %0d", want, got);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return pending_out.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset and DUT hookup. Every input starts at a known level.
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;      // sample_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // sample_out
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   phaser_tracker tracker;

   // per-phase switches that turn off idling on one side
   bit req_no_gaps = 1'b0;
   bit rsp_no_stalls = 1'b0;
   int rsp_hold = 0;

   always #CLK_HALF clock = ~clock;

   six_stage_allpass_phaser_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Mostly back-to-back, some short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2, 3:    return 16'($urandom_range(0, 511) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   // sweep values: ends of the range, above 1.0 (masked to 17 bits) and inside
   function automatic logic [31:0] pick_sweep();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'd65536;
         2:       return $urandom;
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random backpressure, every accepted result is checked.
   // Outputs are read at the edge, before the DUT's registers move.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_output(rsp_tdata);
         if (rsp_hold > 0) begin
            rsp_hold--;
         end else if (rsp_no_stalls || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            rsp_hold = $urandom_range(0, 6);
         end else begin
            rsp_tready <= 1'b0;
            rsp_hold = pick_gap();
         end
      end
   end

   // One request. valid stays up across back-to-back requests so it is never
   // dropped and raised in the same step.
   task automatic send_sample(input logic [15:0] smp);
      int gap;
      gap = req_no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         if (req_tvalid) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 16'($urandom);
         end
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
      tracker.take_sample(smp);
   endtask

   // Close a phase: stop requesting and wait until every result is back,
   // after which the core sits idle and registers may be written.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Leaves csr_valid high so a batch of writes runs back to back.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.apply_write(idx, val);
   endtask

   task automatic random_settings();
      if ($urandom_range(0, 3) != 0) write_reg(REG_SWEEP_MIN, pick_sweep());
      if ($urandom_range(0, 3) != 0) write_reg(REG_SWEEP_MAX, pick_sweep());
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 4))
            0:       write_reg(REG_PHASE_STEP, 32'd0);
            1:       write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
            2, 3:    write_reg(REG_PHASE_STEP, $urandom_range(1, 1 << 24));
            default: write_reg(REG_PHASE_STEP, $urandom);
         endcase
      end
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 3))
            0:       write_reg(REG_FB_GAIN, 32'd0);
            1:       write_reg(REG_FB_GAIN, 32'd32767);
            default: write_reg(REG_FB_GAIN, $urandom);     // upper bits dropped
         endcase
      end
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 4))
            0:       write_reg(REG_MIX_DEPTH, 32'd0);
            1:       write_reg(REG_MIX_DEPTH, 32'd32768);
            2:       write_reg(REG_MIX_DEPTH, 32'd65535);
            default: write_reg(REG_MIX_DEPTH, $urandom);
         endcase
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_START_PHASE, $urandom);
      if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE_7, $urandom);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus: directed corners first, then randomized phases with fresh
   // register settings between them.
   // ------------------------------------------------------------------------
   initial begin
      int guard;
      int p;
      int i;
      tracker = new();
      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      // full-scale steps and sign patterns at the reset settings
      foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i]);
      drain();

      // corner settings: sweep_min above 1.0, sweep_max below sweep_min so the
      // sweep runs downward, quarter-turn LFO step, full feedback, mix depth
      // near 2.0, start in the last quadrant, and ignored indexes
      write_reg(REG_SWEEP_MIN, 32'h0001_FFFF);
      write_reg(REG_SWEEP_MAX, 32'd0);
      write_reg(REG_PHASE_STEP, 32'h4000_0000);
      write_reg(REG_FB_GAIN, 32'd32767);
      write_reg(REG_MIX_DEPTH, 32'd65535);
      write_reg(REG_START_PHASE, 32'hC000_0000);
      write_reg(REG_SPARE_6, $urandom);
      write_reg(REG_SPARE_7, $urandom);
      csr_valid <= 1'b0;
      for (i = 0; i < 10; i++) begin
         if (i % 3 == 0) send_sample(16'h0000);
         else send_sample((i % 2 == 1) ? 16'h7FFF : 16'h8000);
      end
      drain();

      // first random phase runs with no idling at all
      for (p = 0; p < RAND_PHASES; p++) begin
         random_settings();
         req_no_gaps   = (p == 0) || ($urandom_range(0, 3) == 0);
         rsp_no_stalls = (p == 0) || ($urandom_range(0, 3) == 0);
         for (i = 0; i < RUN_SAMPLES; i++) send_sample(pick_sample());
         drain();
      end

      // wait out anything still in flight, then a latency's worth of quiet
      guard = 0;
      while (tracker.pending() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_TICKS) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("sample_out: %0d results never arrived", tracker.pending());
         tracker.mismatches++;
      end

      if (tracker.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #(2 * CLK_HALF * 800000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

### sim.f
rtl/ph6_pkg.sv
rtl/six_stage_allpass_phaser_core.sv
dv/tb.sv
